>>> hdl/rectilinear_polygon_edge_contact_assert.svh
// assertion macros for the polygon edge contact block
// no dependencies; included by the top level
`ifndef RECTILINEAR_POLYGON_EDGE_CONTACT_ASSERT_SVH
`define RECTILINEAR_POLYGON_EDGE_CONTACT_ASSERT_SVH

// same-cycle implication under an active-low reset
`define RPEC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rpec assertion failed");

// next-cycle implication under an active-low reset
`define RPEC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rpec assertion failed");

`endif

>>> hdl/rpec_pkg.sv
// types and constants shared by the polygon edge contact block
// no dependencies
package rpec_pkg;

    localparam int IN_W    = 16;
    localparam int COORD_W = 17;
    localparam int LEN_W   = 17;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pt_t;

    localparam int PT_W = $bits(pt_t);

    typedef enum logic {
        AXIS_H = 1'b0,
        AXIS_V = 1'b1
    } axis_t;

endpackage

>>> hdl/rpec_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module rpec_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/rpec_span_unit.sv
// shared collinear span compare: one axis of one edge pair per use
// depends on rpec_pkg
module rpec_span_unit (
    input  rpec_pkg::pt_t             p1,
    input  rpec_pkg::pt_t             p2,
    input  rpec_pkg::pt_t             q1,
    input  rpec_pkg::pt_t             q2,
    input  rpec_pkg::axis_t           axis,
    input  logic [rpec_pkg::LEN_W-1:0] need,
    output logic                      hit
);
    import rpec_pkg::*;

    logic signed [COORD_W-1:0] a0, a1, b0, b1;
    logic signed [COORD_W-1:0] cp1, cp2, cq1, cq2;
    logic signed [COORD_W-1:0] a_lo, a_hi, b_lo, b_hi, lo, hi;
    logic signed [COORD_W:0]   share;
    logic                      collinear;

    always_comb begin
        case (axis)
            AXIS_H: begin
                a0 = p1.x; a1 = p2.x; b0 = q1.x; b1 = q2.x;
                cp1 = p1.y; cp2 = p2.y; cq1 = q1.y; cq2 = q2.y;
            end
            AXIS_V: begin
                a0 = p1.y; a1 = p2.y; b0 = q1.y; b1 = q2.y;
                cp1 = p1.x; cp2 = p2.x; cq1 = q1.x; cq2 = q2.x;
            end
            default: begin
                a0 = p1.x; a1 = p2.x; b0 = q1.x; b1 = q2.x;
                cp1 = p1.y; cp2 = p2.y; cq1 = q1.y; cq2 = q2.y;
            end
        endcase

        collinear = (cp1 == cp2) && (cq1 == cq2) && (cp1 == cq1);

        a_lo = (a0 < a1) ? a0 : a1;
        a_hi = (a0 < a1) ? a1 : a0;
        b_lo = (b0 < b1) ? b0 : b1;
        b_hi = (b0 < b1) ? b1 : b0;
        hi   = (a_hi < b_hi) ? a_hi : b_hi;
        lo   = (a_lo > b_lo) ? a_lo : b_lo;

        // point contact gives zero, disjoint spans go negative
        share = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        hit   = collinear && (share >= $signed({1'b0, need}));
    end

endmodule

>>> hdl/rectilinear_polygon_edge_contact.sv
// top level: vertex loading, point stores and the edge pair sequencer
// depends on rpec_pkg, rpec_ram, rpec_span_unit, rectilinear_polygon_edge_contact_assert.svh
//
// channel   | ports               | beat carries
// ----------+---------------------+--------------------------------------------
// input     | s_valid / s_ready   | kind, vertex, offset, final_vertex
// result    | m_valid / m_ready   | touching, capacity_exceeded
// config    | cfg_wr_en           | shared_length_min, written at once
//
// a non-final vertex is stored while idle; after a final vertex the check visits
// every edge pair of the F first and S second vertices, stopping early on a hit,
// and is paced by the single span compare unit and one read port per store.
// reset clears counts, overflow flag, sequencer and result valid flag; the
// point stores need no clearing. s_ready is low while the check runs, and a
// finished result holds the sequencer until the result slot is free.
module rectilinear_polygon_edge_contact #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [rpec_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic signed [rpec_pkg::IN_W-1:0] s_vertex_x,
    input  logic signed [rpec_pkg::IN_W-1:0] s_vertex_y,
    input  logic signed [rpec_pkg::IN_W-1:0] s_offset_x,
    input  logic signed [rpec_pkg::IN_W-1:0] s_offset_y,
    input  logic                         s_final_vertex,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_touching,
    output logic                         m_capacity_exceeded
);
    import rpec_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_P1, S_P2, S_Q0, S_Q2, S_H, S_V, S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  first_count_reg, first_count_next;
    logic [CW-1:0]  second_count_reg, second_count_next;
    logic           overflow_reg, overflow_next;
    logic [LEN_W-1:0] min_len_reg, min_len_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    pt_t            p1_reg, p1_next, p2_reg, p2_next;
    pt_t            q1_reg, q1_next, q2_reg, q2_next;
    logic           touch_reg, touch_next;
    logic           m_valid_reg, m_valid_next;
    logic           m_touching_reg, m_touching_next;
    logic           m_cap_reg, m_cap_next;

    logic           in_beat, out_free;
    pt_t            in_pt;
    logic           first_we, second_we;
    logic [IW-1:0]  first_raddr, second_raddr;
    logic [PT_W-1:0] first_rdata, second_rdata;
    axis_t          axis;
    logic           span_hit;
    logic [CW-1:0]  i_inc, j_inc, j_inc2;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign in_pt.x = COORD_W'(s_vertex_x) + COORD_W'(s_offset_x);
    assign in_pt.y = COORD_W'(s_vertex_y) + COORD_W'(s_offset_y);

    // a full store drops the vertex
    assign first_we  = in_beat && !s_kind && (first_count_reg != CNT_MAX);
    assign second_we = in_beat && s_kind && (second_count_reg != CNT_MAX);

    assign i_inc  = i_reg + CW'(1);
    assign j_inc  = j_reg + CW'(1);
    assign j_inc2 = j_reg + CW'(2);

    assign axis = (state_reg == S_V) ? AXIS_V : AXIS_H;

    rpec_ram #(.WIDTH(PT_W), .DEPTH(MAX_VERTICES)) u_first_ram (
        .aclk    (aclk),
        .wr_en   (first_we),
        .wr_addr (first_count_reg[IW-1:0]),
        .wr_data (in_pt),
        .rd_addr (first_raddr),
        .rd_data (first_rdata)
    );

    rpec_ram #(.WIDTH(PT_W), .DEPTH(MAX_VERTICES)) u_second_ram (
        .aclk    (aclk),
        .wr_en   (second_we),
        .wr_addr (second_count_reg[IW-1:0]),
        .wr_data (in_pt),
        .rd_addr (second_raddr),
        .rd_data (second_rdata)
    );

    rpec_span_unit u_span (
        .p1   (p1_reg),
        .p2   (p2_reg),
        .q1   (q1_reg),
        .q2   (q2_reg),
        .axis (axis),
        .need (min_len_reg),
        .hit  (span_hit)
    );

    always_comb begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        min_len_next      = cfg_wr_en ? cfg_wr_data : min_len_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        p1_next           = p1_reg;
        p2_next           = p2_reg;
        q1_next           = q1_reg;
        q2_next           = q2_reg;
        touch_next        = touch_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_touching_next   = m_touching_reg;
        m_cap_next        = m_cap_reg;
        first_raddr       = '0;
        second_raddr      = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    if (first_we) first_count_next = first_count_reg + CW'(1);
                    if (second_we) second_count_next = second_count_reg + CW'(1);
                    if (in_beat && !first_we && !second_we) overflow_next = 1'b1;
                    if (s_final_vertex) state_next = S_START;
                end
            end
            S_START: begin
                touch_next = 1'b0;
                i_next     = '0;
                if (first_count_reg == '0 || second_count_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_P1;
                end
            end
            S_P1: begin
                p1_next     = pt_t'(first_rdata);
                first_raddr = (i_inc == first_count_reg) ? '0 : i_inc[IW-1:0];
                state_next  = S_P2;
            end
            S_P2: begin
                p2_next    = pt_t'(first_rdata);
                j_next     = '0;
                state_next = S_Q0;
            end
            S_Q0: begin
                q1_next      = pt_t'(second_rdata);
                second_raddr = (second_count_reg == CW'(1)) ? '0 : IW'(1);
                state_next   = S_Q2;
            end
            S_Q2: begin
                q2_next    = pt_t'(second_rdata);
                state_next = S_H;
            end
            S_H: begin
                if (span_hit) begin
                    touch_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_V;
                end
            end
            S_V: begin
                if (span_hit) begin
                    touch_next = 1'b1;
                    state_next = S_DONE;
                end else if (j_inc != second_count_reg) begin
                    // slide along the second polygon, closing edge reads index zero
                    j_next       = j_inc;
                    q1_next      = q2_reg;
                    second_raddr = (j_inc2 == second_count_reg) ? '0 : j_inc2[IW-1:0];
                    state_next   = S_Q2;
                end else if (i_inc != first_count_reg) begin
                    i_next      = i_inc;
                    first_raddr = i_inc[IW-1:0];
                    state_next  = S_P1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_touching_next   = touch_reg;
                    m_cap_next        = overflow_reg;
                    first_count_next  = '0;
                    second_count_next = '0;
                    overflow_next     = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // first vertex of the pair is read as soon as the check starts
        if (state_reg == S_START) begin
            first_raddr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            min_len_reg      <= LEN_W'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            min_len_reg      <= min_len_next;
            m_valid_reg      <= m_valid_next;
        end
        i_reg          <= i_next;
        j_reg          <= j_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        q1_reg         <= q1_next;
        q2_reg         <= q2_next;
        touch_reg      <= touch_next;
        m_touching_reg <= m_touching_next;
        m_cap_reg      <= m_cap_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_touching          = m_touching_reg;
    assign m_capacity_exceeded = m_cap_reg;

`include "rectilinear_polygon_edge_contact_assert.svh"

    `RPEC_ASSERT_NOW(a_idx_in_range, aclk, aresetn,
        (state_reg == S_H || state_reg == S_V),
        (i_reg < first_count_reg && j_reg < second_count_reg))

    `RPEC_ASSERT_NEXT(a_final_starts_check, aclk, aresetn,
        (in_beat && s_final_vertex), (state_reg == S_START))

    `RPEC_ASSERT_NEXT(a_result_clears_load, aclk, aresetn,
        (state_reg == S_DONE && out_free),
        (m_valid_reg && first_count_reg == '0 && second_count_reg == '0 && !overflow_reg))

endmodule

>>> tb/rpec_contact_checker.sv
`timescale 1ns / 100ps
// result checker for rectilinear_polygon_edge_contact: keeps its own copy of both point
// stores and of shared_length_min, and compares every result beat with the oldest verdict due
// depends on rpec_pkg
module rpec_contact_checker #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rpec_pkg::LEN_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_kind,
    input  logic signed [rpec_pkg::IN_W-1:0]  s_vertex_x,
    input  logic signed [rpec_pkg::IN_W-1:0]  s_vertex_y,
    input  logic signed [rpec_pkg::IN_W-1:0]  s_offset_x,
    input  logic signed [rpec_pkg::IN_W-1:0]  s_offset_y,
    input  logic                              s_final_vertex,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_touching,
    input  logic                              m_capacity_exceeded,
    output int                                mismatch_count,
    output int                                outstanding
);
    import rpec_pkg::*;

    typedef struct packed {
        logic touching;
        logic capacity_exceeded;
    } verdict_t;

    pt_t              first_store [MAX_VERTICES];
    pt_t              second_store [MAX_VERTICES];
    int unsigned      first_used;
    int unsigned      second_used;
    logic             vertex_dropped;
    logic [LEN_W-1:0] min_shared_len;
    verdict_t         verdicts_due [$];
    int               errors = 0;

    // world coordinate in 17 bits, so the sum never wraps
    function automatic logic signed [COORD_W-1:0] world(input logic signed [IN_W-1:0] rel,
                                                        input logic signed [IN_W-1:0] offs);
        return {rel[IN_W-1], rel} + {offs[IN_W-1], offs};
    endfunction

    function automatic int imin(input int a, input int b);
        return a < b ? a : b;
    endfunction

    function automatic int imax(input int a, input int b);
        return a > b ? a : b;
    endfunction

    // overlap of two spans, ends in either order; negative when apart
    function automatic int shared_len(input int a0, input int a1, input int b0, input int b1);
        return imin(imax(a0, a1), imax(b0, b1)) - imax(imin(a0, a1), imin(b0, b1));
    endfunction

    function automatic logic loads_touch();
        pt_t p1, p2, q1, q2;
        int  need;
        need = int'(min_shared_len);
        for (int i = 0; i < first_used; i++) begin
            p1 = first_store[i];
            p2 = first_store[(i + 1) % first_used];
            for (int j = 0; j < second_used; j++) begin
                q1 = second_store[j];
                q2 = second_store[(j + 1) % second_used];
                // point edges pass both tests, being level and upright at once
                if (p1.y == p2.y && q1.y == q2.y && p1.y == q1.y &&
                    shared_len($signed(p1.x), $signed(p2.x),
                               $signed(q1.x), $signed(q2.x)) >= need)
                    return 1'b1;
                if (p1.x == p2.x && q1.x == q2.x && p1.x == q1.x &&
                    shared_len($signed(p1.y), $signed(p2.y),
                               $signed(q1.y), $signed(q2.y)) >= need)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin : track
        verdict_t due;
        pt_t      pt;
        if (!aresetn) begin
            first_used     = 0;
            second_used    = 0;
            vertex_dropped = 1'b0;
            min_shared_len = 1;
            verdicts_due.delete();
        end else begin
            if (cfg_wr_en) begin
                min_shared_len = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result beat with none due: touching=%b capacity_exceeded=%b",
                             $time, m_touching, m_capacity_exceeded);
                    errors++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (m_touching !== due.touching) begin
                        $display("%0t: touching expected %b actual %b",
                                 $time, due.touching, m_touching);
                        errors++;
                    end
                    if (m_capacity_exceeded !== due.capacity_exceeded) begin
                        $display("%0t: capacity_exceeded expected %b actual %b",
                                 $time, due.capacity_exceeded, m_capacity_exceeded);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pt.x = world(s_vertex_x, s_offset_x);
                pt.y = world(s_vertex_y, s_offset_y);
                if (s_kind == 1'b0) begin
                    if (first_used < MAX_VERTICES) begin
                        first_store[first_used] = pt;
                        first_used++;
                    end else begin
                        vertex_dropped = 1'b1;
                    end
                end else begin
                    if (second_used < MAX_VERTICES) begin
                        second_store[second_used] = pt;
                        second_used++;
                    end else begin
                        vertex_dropped = 1'b1;
                    end
                end
                if (s_final_vertex) begin
                    due.touching          = loads_touch();
                    due.capacity_exceeded = vertex_dropped;
                    verdicts_due          = {verdicts_due, due};
                    first_used     = 0;
                    second_used    = 0;
                    vertex_dropped = 1'b0;
                end
            end
        end
        mismatch_count <= errors;
        outstanding    <= verdicts_due.size();
    end

endmodule

>>> tb/rectilinear_polygon_edge_contact_test.sv
`timescale 1ns / 100ps
// top of the testbench for rectilinear_polygon_edge_contact: clock, reset, vertex and
// config stimulus, result back-pressure and the verdict; checking sits in rpec_contact_checker
// depends on rpec_pkg, rpec_contact_checker and the block itself
module rectilinear_polygon_edge_contact_test;
    import rpec_pkg::*;

    localparam int MAX_VERTICES  = 32;
    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 240;
    localparam int PHASE_COUNT   = 6;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [LEN_W-1:0]       cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_kind;
    logic signed [IN_W-1:0] s_vertex_x;
    logic signed [IN_W-1:0] s_vertex_y;
    logic signed [IN_W-1:0] s_offset_x;
    logic signed [IN_W-1:0] s_offset_y;
    logic                   s_final_vertex;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_touching;
    logic                   m_capacity_exceeded;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;
    int loads_sent  = 0;
    int hold_left   = 0;
    bit stall_mode  = 1'b1;
    bit steady      = 1'b0;

    rectilinear_polygon_edge_contact #(
        .MAX_VERTICES(MAX_VERTICES)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_vertex_x         (s_vertex_x),
        .s_vertex_y         (s_vertex_y),
        .s_offset_x         (s_offset_x),
        .s_offset_y         (s_offset_y),
        .s_final_vertex     (s_final_vertex),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_touching         (m_touching),
        .m_capacity_exceeded(m_capacity_exceeded)
    );

    rpec_contact_checker #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_contact_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_vertex_x         (s_vertex_x),
        .s_vertex_y         (s_vertex_y),
        .s_offset_x         (s_offset_x),
        .s_offset_y         (s_offset_y),
        .s_final_vertex     (s_final_vertex),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_touching         (m_touching),
        .m_capacity_exceeded(m_capacity_exceeded),
        .mismatch_count     (mismatch_count),
        .outstanding        (outstanding)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rectilinear_polygon_edge_contact_test: FAIL");
            $finish;
        end
    end

    // result side back-pressure, in random bursts, with quiet stretches
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) begin
            stall_mode <= !stall_mode;
        end
        if (steady || !stall_mode) begin
            m_ready <= 1'b1;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready   <= 1'b0;
            hold_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // returns just after the accepting edge with valid still high; whatever follows
    // starts at the next falling edge and either drives a new beat or drops valid
    task automatic send_vertex(input logic kind,
                               input logic signed [IN_W-1:0] vx, input logic signed [IN_W-1:0] vy,
                               input logic signed [IN_W-1:0] ox, input logic signed [IN_W-1:0] oy,
                               input logic last);
        @(negedge aclk);
        if (stall_mode && !steady && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_vertex_x     <= vx;
        s_vertex_y     <= vy;
        s_offset_x     <= ox;
        s_offset_y     <= oy;
        s_final_vertex <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_for_verdicts();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic load_min_length(input logic [LEN_W-1:0] value);
        wait_for_verdicts();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one level edge across the whole world range, in both polygons
    task automatic send_full_span_pair();
        send_vertex(1'b0, -32768, 32767, -32768, 32767, 1'b0);
        send_vertex(1'b0, 32767, 32767, 32767, 32767, 1'b0);
        send_vertex(1'b1, -32768, 32767, -32768, 32767, 1'b0);
        send_vertex(1'b1, 32767, 32767, 32767, 32767, 1'b1);
    endtask

    function automatic logic signed [IN_W-1:0] rand_coord(input int span);
        return IN_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 75) return $urandom_range(1, 6);
        if (r < 96) return $urandom_range(7, 16);
        return $urandom_range(30, 36);
    endfunction

    // rectilinear outline: steps alternate between x and y, and from four vertices
    // on the last step returns to the start row or column so the closing edge is straight
    task automatic send_outline(input logic kind, input int count,
                                input logic signed [IN_W-1:0] ox,
                                input logic signed [IN_W-1:0] oy,
                                input int span, input logic ends_load);
        logic signed [IN_W-1:0] x0, y0, x, y;
        logic                   last;
        x0 = rand_coord(span);
        y0 = rand_coord(span);
        x  = x0;
        y  = y0;
        for (int i = 0; i < count; i++) begin
            last = (i == count - 1);
            if (i % 2 == 1) begin
                x = (last && count >= 4) ? x0 : rand_coord(span);
            end else if (i > 0) begin
                y = (last && count >= 4) ? y0 : rand_coord(span);
            end
            send_vertex(kind, x, y, ox, oy, ends_load && last);
        end
    endtask

    task automatic send_outline_pair();
        int                     n1, n2, span;
        logic signed [IN_W-1:0] ox1, oy1, ox2, oy2;
        n1 = pick_size();
        n2 = pick_size();
        if (loads_sent == 0) n1 = 34;
        if (loads_sent == 1) n2 = 35;
        if (n1 == 0 && n2 == 0) n1 = 1;
        if ($urandom_range(0, 1)) begin
            ox1 = IN_W'($urandom);
            oy1 = IN_W'($urandom);
        end else begin
            ox1 = rand_coord(100);
            oy1 = rand_coord(100);
        end
        if ($urandom_range(0, 1)) begin
            ox2 = ox1;
            oy2 = oy1;
        end else begin
            ox2 = ox1 + rand_coord(4);
            oy2 = oy1 + rand_coord(4);
        end
        case ($urandom_range(0, 3))
            0: span = 2;
            1: span = 5;
            2: span = 12;
            default: span = 3000;
        endcase
        send_outline(1'b0, n1, ox1, oy1, span, n2 == 0);
        send_outline(1'b1, n2, ox2, oy2, span, 1'b1);
        loads_sent++;
    endtask

    // mixed polygons, full-range values, final flag on either kind
    task automatic send_scrambled_load();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            send_vertex(1'($urandom), IN_W'($urandom), IN_W'($urandom),
                        IN_W'($urandom), IN_W'($urandom), i == n - 1);
        end
        loads_sent++;
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] min_len;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_kind         = 1'b0;
        s_vertex_x     = '0;
        s_vertex_y     = '0;
        s_offset_x     = '0;
        s_offset_y     = '0;
        s_final_vertex = 1'b0;
        m_ready        = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // minimum length at its reset value
        send_vertex(1'b0, 0, 0, 0, 0, 1'b1);           // second polygon empty
        send_vertex(1'b0, 5, 5, 0, 0, 1'b0);           // two single points, same place
        send_vertex(1'b1, 2, 2, 3, 3, 1'b1);
        send_full_span_pair();
        send_vertex(1'b0, -32768, -32768, -32768, -32768, 1'b0);
        send_vertex(1'b0, -32768, 32767, -32768, 32767, 1'b0);
        send_vertex(1'b1, -32768, 0, -32768, 0, 1'b0);
        send_vertex(1'b1, -32768, 10, -32768, 0, 1'b1);
        send_vertex(1'b0, 0, 0, 0, 0, 1'b0);           // edges meet end to end only
        send_vertex(1'b0, 10, 0, 0, 0, 1'b0);
        send_vertex(1'b1, 10, 0, 0, 0, 1'b0);
        send_vertex(1'b1, 20, 0, 0, 0, 1'b1);
        load_min_length(0);
        send_vertex(1'b0, 5, 5, 0, 0, 1'b0);
        send_vertex(1'b1, 2, 2, 3, 3, 1'b1);
        load_min_length(131070);
        send_full_span_pair();
        load_min_length(131071);
        send_full_span_pair();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: min_len = 1;
                1: min_len = 0;
                2: min_len = LEN_W'($urandom_range(2, 8));
                3: min_len = 131071;
                4: min_len = LEN_W'($urandom_range(0, 131071));
                default: min_len = LEN_W'($urandom_range(1, 4));
            endcase
            load_min_length(min_len);
            steady = (p == PHASE_COUNT - 1);
            while (items_sent < 25 + (p + 1) * PHASE_ITEMS) begin
                if ($urandom_range(0, 11) == 0) begin
                    wait_for_verdicts();
                end
                if ($urandom_range(0, 6) == 0) begin
                    send_scrambled_load();
                end else begin
                    send_outline_pair();
                end
            end
        end

        wait_for_verdicts();
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("rectilinear_polygon_edge_contact_test: PASS");
        end else begin
            $display("rectilinear_polygon_edge_contact_test: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/rpec_pkg.sv
hdl/rpec_ram.sv
hdl/rpec_span_unit.sv
hdl/rectilinear_polygon_edge_contact.sv
tb/rpec_contact_checker.sv
tb/rectilinear_polygon_edge_contact_test.sv
